[rtl/sha256_stream_hasher_defines.svh]
// Assertion macros shared by the checker.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SHA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/sha_pkg.sv]
`default_nettype none
package sha_pkg;
  typedef enum logic [2:0] {
    ST_LOAD, ST_INIT, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
  } state_t;

  typedef struct packed {
    logic wr_byte;     // store in_msg_byte at fill pointer, count length
    logic wr_pad;      // store the pad byte for the current pad position
    logic init;        // load working vars from hash words
    logic round;       // one compression round
    logic add;         // fold working vars into hash words
    logic emit_shift;  // rotate hash words for output
    logic clear;       // back to initial values
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] rnd;
    logic       end_pending;
    logic       last_blk;    // the block being padded carries the length
  } stat_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

[rtl/sha_ctrl.sv]
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  in_byte_present,
  input  wire logic  in_message_end,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0] emit_idx,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       set_end,
  output logic       clr_end
);
  state_t     state_r, state_nxt;
  logic [2:0] emit_r, emit_nxt;
  logic       in_acc;

  assign in_acc   = in_valid && in_ready;
  assign emit_idx = emit_r;

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_byte_present && stat.fill == 6'd63) state_nxt = ST_INIT;
          else if (in_message_end) state_nxt = ST_PAD;
        end
      end
      ST_INIT: state_nxt = ST_ROUND;
      ST_ROUND: if (stat.rnd == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        // After the block that holds the length, the digest goes out.
        if (!stat.end_pending) state_nxt = ST_LOAD;
        else if (stat.last_blk) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_PAD: begin
        // The pad sweep ends at a block boundary.
        if (stat.fill == 6'd63) state_nxt = ST_INIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          emit_nxt = emit_r + 3'd1;
          if (emit_r == 3'd7) state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    set_end   = 1'b0;
    clr_end   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready    = 1'b1;
        cmd.wr_byte = in_acc && in_byte_present;
        set_end     = in_acc && in_message_end;
      end
      ST_INIT:  cmd.init  = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_ADD:   cmd.add   = 1'b1;
      ST_PAD:   cmd.wr_pad = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit_shift = out_ready;
        cmd.clear = out_ready && emit_r == 3'd7;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      emit_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= (state_r == ST_EMIT) ? emit_nxt : 3'd0;
    end
  end
endmodule
`default_nettype wire

[rtl/sha_dp.sv]
`default_nettype none
module sha_dp
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_msg_byte,
  input  wire cmd_t        cmd,
  input  wire logic        set_end,
  input  wire logic        clr_end,
  input  wire logic [2:0]  emit_idx,
  output stat_t            stat,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] blk_r [16];
  logic [5:0]  fill_r, rnd_r;
  logic [63:0] len_r;
  logic        endp_r, final_r, padded_r;
  logic [31:0] w_t, s0, s1, t1, t2, e, a;
  logic [7:0]  pad_b;
  logic [4:0]  lane_hi;

  // Bytes are packed big-endian into the sixteen message words.
  assign lane_hi = 5'd31 - {fill_r[1:0], 3'b000};

  always_comb begin
    a  = v_r[0];
    e  = v_r[4];
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    if (rnd_r < 6'd16)
      w_t = blk_r[rnd_r[3:0]];
    else
      w_t = s1 + w_r[9] + s0 + w_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + ROUND_K[rnd_r] + w_t;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    // Pad byte: 0x80 first, zeros, then the length in the last eight slots
    // of the final block.
    if (!padded_r) pad_b = PAD_BYTE;
    else if (final_r && fill_r >= 6'd56) pad_b = len_r[8'd63 - {fill_r[2:0], 3'b000} -: 8];
    else pad_b = 8'h00;
  end

  // The final block is the one where the length still fits after the pad.
  logic final_nxt;
  assign final_nxt = padded_r ? final_r : (fill_r < 6'd56);

  assign stat = '{fill: fill_r, rnd: rnd_r, end_pending: endp_r, last_blk: final_r};

  assign out_digest_word = h_r[0];
  assign out_word_index  = emit_idx;
  assign out_last_word   = (emit_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) blk_r[fill_r[5:2]][lane_hi -: 8] <= in_msg_byte;
    if (cmd.wr_pad)  blk_r[fill_r[5:2]][lane_hi -: 8] <= pad_b;
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_t;
      for (int i = 1; i < 8; i++) v_r[i] <= v_r[i - 1];
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
    if (cmd.init) for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
      fill_r <= 6'd0; len_r <= 64'd0; rnd_r <= 6'd0;
      endp_r <= 1'b0; final_r <= 1'b0; padded_r <= 1'b0;
    end else begin
      if (cmd.wr_byte) begin
        fill_r <= fill_r + 6'd1;
        len_r  <= len_r + 64'd8;
      end
      if (set_end || clr_end) endp_r <= set_end;
      if (cmd.wr_pad) begin
        fill_r   <= fill_r + 6'd1;
        padded_r <= 1'b1;
        final_r  <= final_nxt;
      end
      if (cmd.init) rnd_r <= 6'd0;
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        // A pad block that was not final means one more (final) block follows.
        if (padded_r && !final_r) final_r <= 1'b1;
      end
      if (cmd.emit_shift)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[(i + 1) % 8];
    end
  end
endmodule
`default_nettype wire

[rtl/sha256_stream_hasher.sv]
// SHA-256 hasher over a byte stream.
// Input channel: in_valid/in_ready with in_msg_byte, in_byte_present and
// in_message_end. A word with byte_present appends one byte; a word with
// message_end (byte first, if present) finishes the message.
// Output channel: out_valid/out_ready carries the eight digest words H0..H7
// in order, with out_word_index and out_last_word on the eighth.
// Plain bytes are taken one per cycle while in_ready is high; every 64th
// byte starts a compression (load, 64 rounds of the single round unit,
// add). A message end runs a pad sweep to the end of the block plus its
// compression, one or two blocks, then the digest words, one per cycle
// while out_ready is high.
// Input is not taken during compression, padding or digest output.
// A stalled receiver holds the current digest word until it is taken.
// Reset loads the initial hash values and clears the byte and bit counts;
// the block is ready for input in the first cycle after reset.
`default_nettype none
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_msg_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_message_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] emit_idx;
  logic       set_end, clr_end;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte_present, .in_message_end,
    .out_valid, .out_ready, .emit_idx, .stat, .cmd, .set_end, .clr_end
  );

  sha_dp u_dp (
    .clk, .rst_n, .in_msg_byte, .cmd, .set_end, .clr_end, .emit_idx, .stat,
    .out_digest_word, .out_word_index, .out_last_word
  );
endmodule
`default_nettype wire

[rtl/sha_checker.sv]
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_word_index,
  input wire logic        out_last_word
);
  `SHA_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `SHA_ASSERT_IMP(a_last_idx, clk, rst_n, out_valid, out_last_word == (out_word_index == 3'd7))
  `SHA_ASSERT_NXT(a_idx_step, clk, rst_n, out_valid && out_ready && !out_last_word,
                  out_valid && out_word_index == $past(out_word_index) + 3'd1)
  `SHA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_word_index))
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_word_index, .out_last_word
);
`default_nettype wire
